FILE: rtl/lpbm_pkg.sv
// lpbm_pkg: shared widths and constants for the lru page buffer manager
// no dependencies; used by lru_page_buffer_manager_top

package lpbm_pkg;

  // fixed widths of the word fields on the ports
  localparam int PAGE_W  = 16;
  localparam int FRAME_W = 6;
  localparam int HIT_W   = 32;

  // saturation value of the hit counter
  localparam logic [HIT_W-1:0] HIT_MAX = '1;

endpackage

FILE: rtl/lpbm_scan.sv
// lpbm_scan: tag match and lru victim tracker over a stream of frame table reads
// depends on nothing but its parameters; instantiated by lru_page_buffer_manager_top

module lpbm_scan #(
  parameter int IDX_W = 6,
  parameter int TAG_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             dv,
  input  logic [IDX_W-1:0] d_idx,
  input  logic [TAG_W-1:0] d_tag,
  input  logic [IDX_W-1:0] d_rank,
  input  logic             d_dirty,
  input  logic [TAG_W-1:0] key,
  output logic             res_hit,
  output logic [IDX_W-1:0] res_hit_idx,
  output logic [IDX_W-1:0] res_hit_rank,
  output logic [IDX_W-1:0] res_vic_idx,
  output logic [IDX_W-1:0] res_vic_rank,
  output logic             res_vic_dirty,
  output logic [TAG_W-1:0] res_vic_tag
);

  logic             hit_r, hit_nxt;
  logic             any_r, any_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0] hit_rank_r, hit_rank_nxt;
  logic [IDX_W-1:0] vic_idx_r, vic_idx_nxt;
  logic [IDX_W-1:0] vic_rank_r, vic_rank_nxt;
  logic             vic_dirty_r, vic_dirty_nxt;
  logic [TAG_W-1:0] vic_tag_r, vic_tag_nxt;

  always_comb begin
    hit_nxt       = hit_r;
    any_nxt       = any_r;
    hit_idx_nxt   = hit_idx_r;
    hit_rank_nxt  = hit_rank_r;
    vic_idx_nxt   = vic_idx_r;
    vic_rank_nxt  = vic_rank_r;
    vic_dirty_nxt = vic_dirty_r;
    vic_tag_nxt   = vic_tag_r;
    if (start) begin
      hit_nxt = 1'b0;
      any_nxt = 1'b0;
    end else if (dv) begin
      // first matching frame wins
      if (!hit_r && (d_tag == key)) begin
        hit_nxt      = 1'b1;
        hit_idx_nxt  = d_idx;
        hit_rank_nxt = d_rank;
      end
      // strictly higher rank only, so ties keep the lowest frame
      if (!any_r || (d_rank > vic_rank_r)) begin
        any_nxt       = 1'b1;
        vic_idx_nxt   = d_idx;
        vic_rank_nxt  = d_rank;
        vic_dirty_nxt = d_dirty;
        vic_tag_nxt   = d_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
      any_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
      any_r <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r   <= hit_idx_nxt;
    hit_rank_r  <= hit_rank_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_rank_r  <= vic_rank_nxt;
    vic_dirty_r <= vic_dirty_nxt;
    vic_tag_r   <= vic_tag_nxt;
  end

  assign res_hit       = hit_r;
  assign res_hit_idx   = hit_idx_r;
  assign res_hit_rank  = hit_rank_r;
  assign res_vic_idx   = vic_idx_r;
  assign res_vic_rank  = vic_rank_r;
  assign res_vic_dirty = vic_dirty_r;
  assign res_vic_tag   = vic_tag_r;

endmodule

FILE: rtl/lru_page_buffer_manager_top.sv
// lru_page_buffer_manager_top: maps page requests to buffer frames with lru replacement
// depends on lpbm_pkg and lpbm_scan
//
// usage
// - input channel: in_valid / in_stall carry one request word (page number, write flag)
// - result channel: out_valid / out_stall carry one result word per request
// - frame table (tag, recency rank, dirty) sits in one synchronous ram with a registered read
// - frames fill in order from frame 0 and are never freed, so a fill count marks
//   which frames are valid; no clearing pass is needed after reset
// - each request: a scan pass reads every frame in use (tag match, lru victim),
//   a decide state, then a read-modify-write pass updates the ranks
// - the scan pass reads the N frames in use before the request, and the update pass
//   touches M frames (M = N, or N + 1 on allocation of a new frame)
// - the next request is taken in the cycle after the word is loaded; requests do not
//   overlap, as the single read port walks the table twice for each one
// - one request at a time: in_stall is low only between requests
// - a finished word waits in the output register while the next request is taken;
//   a stalled receiver holds the word steady and delays only the next result
// - reset (synchronous, rst_n low) empties the table and clears the hit counter

module lru_page_buffer_manager_top #(
  parameter int FRAMES    = 64,
  parameter int PAGE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lpbm_pkg::PAGE_W-1:0]  in_page_number,
  input  logic                       in_is_write,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lpbm_pkg::FRAME_W-1:0] out_frame_index,
  output logic                       out_was_hit,
  output logic                       out_fetch_needed,
  output logic                       out_writeback_needed,
  output logic [lpbm_pkg::PAGE_W-1:0]  out_evicted_page,
  output logic [lpbm_pkg::HIT_W-1:0]   out_hit_total
);

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int TAG_W  = PAGE_BITS;
  localparam int WORD_W = 1 + IDX_W + TAG_W;

  // controller states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [CNT_W-1:0] FRAMES_C = CNT_W'(FRAMES);
  localparam logic [CNT_W-1:0] ONE_C    = CNT_W'(1);

  // control registers
  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] n_upd_r, n_upd_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [lpbm_pkg::HIT_W-1:0] hit_cnt_r, hit_cnt_nxt;

  // per request payload registers
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [TAG_W-1:0] page_r, page_nxt;
  logic             wr_r, wr_nxt;
  logic [IDX_W-1:0] f_r, f_nxt;
  logic [IDX_W-1:0] lim_r, lim_nxt;
  logic             lim_inf_r, lim_inf_nxt;
  logic             hit_r, hit_nxt;
  logic             wb_r, wb_nxt;
  logic [TAG_W-1:0] evict_r, evict_nxt;

  // output word registers
  logic [lpbm_pkg::FRAME_W-1:0] o_frame_r, o_frame_nxt;
  logic                       o_hit_r, o_hit_nxt;
  logic                       o_fetch_r, o_fetch_nxt;
  logic                       o_wb_r, o_wb_nxt;
  logic [lpbm_pkg::PAGE_W-1:0]  o_evict_r, o_evict_nxt;
  logic [lpbm_pkg::HIT_W-1:0]   o_total_r, o_total_nxt;

  // frame table ram: {dirty, rank, tag}
  logic [WORD_W-1:0] mem_r [FRAMES];
  logic [WORD_W-1:0] rd_data_r;
  logic              mem_re, mem_we;
  logic [IDX_W-1:0]  mem_ra, mem_wa;
  logic [WORD_W-1:0] mem_wd;

  logic [TAG_W-1:0] rd_tag;
  logic [IDX_W-1:0] rd_rank;
  logic             rd_dirty;

  logic [TAG_W-1:0]           key_in;
  logic [lpbm_pkg::FRAME_W-1:0] f_out;
  logic [lpbm_pkg::PAGE_W-1:0]  evict_out;

  logic             scan_start, scan_dv;
  logic             sc_hit;
  logic [IDX_W-1:0] sc_hit_idx, sc_hit_rank, sc_vic_idx, sc_vic_rank;
  logic             sc_vic_dirty;
  logic [TAG_W-1:0] sc_vic_tag;

  logic in_acc;
  logic out_free;
  logic rank_inc;

  assign rd_tag   = rd_data_r[TAG_W-1:0];
  assign rd_rank  = rd_data_r[TAG_W +: IDX_W];
  assign rd_dirty = rd_data_r[WORD_W-1];

  // page number to tag width, and back out to port widths
  generate
    if (TAG_W == lpbm_pkg::PAGE_W) begin : g_key_same
      assign key_in    = in_page_number;
      assign evict_out = evict_r;
    end else if (TAG_W < lpbm_pkg::PAGE_W) begin : g_key_narrow
      assign key_in    = in_page_number[TAG_W-1:0];
      assign evict_out = {{(lpbm_pkg::PAGE_W - TAG_W){1'b0}}, evict_r};
    end else begin : g_key_wide
      assign key_in    = {{(TAG_W - lpbm_pkg::PAGE_W){1'b0}}, in_page_number};
      assign evict_out = evict_r[lpbm_pkg::PAGE_W-1:0];
    end
    if (IDX_W >= lpbm_pkg::FRAME_W) begin : g_f_wide
      assign f_out = f_r[lpbm_pkg::FRAME_W-1:0];
    end else begin : g_f_narrow
      assign f_out = {{(lpbm_pkg::FRAME_W - IDX_W){1'b0}}, f_r};
    end
  endgenerate

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_vld_r || !out_stall;

  assign scan_start = in_acc;
  assign scan_dv    = rd_vld_r && (state_r == ST_SCAN);

  lpbm_scan #(
    .IDX_W (IDX_W),
    .TAG_W (TAG_W)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (scan_start),
    .dv            (scan_dv),
    .d_idx         (rd_idx_r),
    .d_tag         (rd_tag),
    .d_rank        (rd_rank),
    .d_dirty       (rd_dirty),
    .key           (page_r),
    .res_hit       (sc_hit),
    .res_hit_idx   (sc_hit_idx),
    .res_hit_rank  (sc_hit_rank),
    .res_vic_idx   (sc_vic_idx),
    .res_vic_rank  (sc_vic_rank),
    .res_vic_dirty (sc_vic_dirty),
    .res_vic_tag   (sc_vic_tag)
  );

  // rank ageing: frames more recent than the limit move back by one
  assign rank_inc = lim_inf_r || (rd_rank < lim_r);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    used_nxt    = used_r;
    n_upd_nxt   = n_upd_r;
    rd_vld_nxt  = 1'b0;
    rd_idx_nxt  = rd_idx_r;
    hit_cnt_nxt = hit_cnt_r;
    page_nxt    = page_r;
    wr_nxt      = wr_r;
    f_nxt       = f_r;
    lim_nxt     = lim_r;
    lim_inf_nxt = lim_inf_r;
    hit_nxt     = hit_r;
    wb_nxt      = wb_r;
    evict_nxt   = evict_r;
    o_frame_nxt = o_frame_r;
    o_hit_nxt   = o_hit_r;
    o_fetch_nxt = o_fetch_r;
    o_wb_nxt    = o_wb_r;
    o_evict_nxt = o_evict_r;
    o_total_nxt = o_total_r;
    out_vld_nxt = out_vld_r && out_stall;
    mem_re      = 1'b0;
    mem_ra      = idx_r[IDX_W-1:0];
    mem_we      = 1'b0;
    mem_wa      = rd_idx_r;
    mem_wd      = rd_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          page_nxt  = key_in;
          wr_nxt    = in_is_write;
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // walk frames in use; data lands in the cycle after its address
        if (idx_r < used_r) begin
          mem_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt    = idx_r + ONE_C;
        end else if (!rd_vld_r) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        idx_nxt     = '0;
        n_upd_nxt   = used_r;
        lim_inf_nxt = 1'b0;
        hit_nxt     = 1'b0;
        wb_nxt      = 1'b0;
        evict_nxt   = '0;
        if (sc_hit) begin
          hit_nxt = 1'b1;
          f_nxt   = sc_hit_idx;
          lim_nxt = sc_hit_rank;
          if (hit_cnt_r != lpbm_pkg::HIT_MAX) begin
            hit_cnt_nxt = hit_cnt_r + lpbm_pkg::HIT_W'(1);
          end
        end else if (used_r != FRAMES_C) begin
          // lowest free frame is the next one past the filled range
          f_nxt       = used_r[IDX_W-1:0];
          lim_inf_nxt = 1'b1;
          n_upd_nxt   = used_r + ONE_C;
          used_nxt    = used_r + ONE_C;
        end else begin
          // table full: evict the least recent frame
          f_nxt   = sc_vic_idx;
          lim_nxt = sc_vic_rank;
          wb_nxt  = sc_vic_dirty;
          if (sc_vic_dirty) begin
            evict_nxt = sc_vic_tag;
          end
        end
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (idx_r < n_upd_r) begin
          mem_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt    = idx_r + ONE_C;
        end else if (!rd_vld_r) begin
          state_nxt = ST_DONE;
        end
        // write back behind the read, never the entry being read
        if (rd_vld_r) begin
          mem_we = 1'b1;
          if (rd_idx_r == f_r) begin
            mem_wd = {wr_r | (hit_r & rd_dirty), {IDX_W{1'b0}}, page_r};
          end else if (rank_inc) begin
            mem_wd = {rd_dirty, rd_rank + IDX_W'(1), rd_tag};
          end else begin
            mem_wd = rd_data_r;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          o_frame_nxt = f_out;
          o_hit_nxt   = hit_r;
          o_fetch_nxt = !hit_r && !wr_r;
          o_wb_nxt    = wb_r;
          o_evict_nxt = evict_out;
          o_total_nxt = hit_cnt_r;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem_r[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      used_r    <= '0;
      n_upd_r   <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      hit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      used_r    <= used_nxt;
      n_upd_r   <= n_upd_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
      hit_cnt_r <= hit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    page_r    <= page_nxt;
    wr_r      <= wr_nxt;
    f_r       <= f_nxt;
    lim_r     <= lim_nxt;
    lim_inf_r <= lim_inf_nxt;
    hit_r     <= hit_nxt;
    wb_r      <= wb_nxt;
    evict_r   <= evict_nxt;
    o_frame_r <= o_frame_nxt;
    o_hit_r   <= o_hit_nxt;
    o_fetch_r <= o_fetch_nxt;
    o_wb_r    <= o_wb_nxt;
    o_evict_r <= o_evict_nxt;
    o_total_r <= o_total_nxt;
  end

  assign out_valid            = out_vld_r;
  assign out_frame_index      = o_frame_r;
  assign out_was_hit          = o_hit_r;
  assign out_fetch_needed     = o_fetch_r;
  assign out_writeback_needed = o_wb_r;
  assign out_evicted_page     = o_evict_r;
  assign out_hit_total        = o_total_r;

  // fill count never passes the table size
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= FRAMES_C)
    else $error("fill count beyond frame count");

  // a writeback can only come from an eviction of a full table
  a_wb_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free && wb_r) |-> (used_r == FRAMES_C && !hit_r))
    else $error("writeback without a full table");

  // a hit never asks for a fetch
  a_hit_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(o_hit_r && o_fetch_r))
    else $error("hit with fetch");

  // ram data beats only inside the two table passes
  a_rd_phase: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SCAN || state_r == ST_UPDATE))
    else $error("read beat outside a pass");

  // hit counter never goes backwards
  a_hit_mono: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> hit_cnt_r >= $past(hit_cnt_r))
    else $error("hit counter went backwards");

endmodule
